@@ src/min_steps_to_one_dp_unit_defines.svh @@
// Assertion helpers for the RTL, included by msto_engine.
`ifndef MIN_STEPS_TO_ONE_DP_UNIT_DEFINES_SVH
`define MIN_STEPS_TO_ONE_DP_UNIT_DEFINES_SVH

// Explicit clock and active-low reset.
`define MSTO_ASSERT_AT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default clock and reset of this block.
`define MSTO_ASSERT(label, prop, msg) \
  `MSTO_ASSERT_AT(label, clk_i, rst_ni, prop, msg)

`endif

@@ src/msto_pkg.sv @@
package msto_pkg;

  localparam int unsigned N_W    = 12;
  localparam int unsigned COST_W = 6;

  localparam logic [COST_W-1:0] COST_MAX  = 6'd63;
  localparam logic [COST_W-1:0] COST_ZERO = 6'd0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EXTEND
  } state_e;

  // Finished result handed from the engine to the output register.
  typedef struct packed {
    logic              valid;
    logic [COST_W-1:0] count;
  } res_t;

endpackage

@@ src/msto_req_if.sv @@
interface msto_req_if;
  import msto_pkg::*;

  logic           valid;
  logic           ready;
  logic [N_W-1:0] n_value;

  modport source (output valid, output n_value, input ready);
  modport sink   (input valid, input n_value, output ready);
endinterface

@@ src/msto_rsp_if.sv @@
interface msto_rsp_if;
  import msto_pkg::*;

  logic              valid;
  logic              ready;
  logic [COST_W-1:0] step_count;

  modport source (output valid, output step_count, input ready);
  modport sink   (input valid, input step_count, output ready);
endinterface

@@ src/msto_cost_ram.sv @@
module msto_cost_ram import msto_pkg::*; #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [AW-1:0]     wr_addr_i,
  input  logic [COST_W-1:0] wr_data_i,
  input  logic [AW-1:0]     rd_a_addr_i,
  input  logic [AW-1:0]     rd_b_addr_i,
  output logic [COST_W-1:0] rd_a_data_o,
  output logic [COST_W-1:0] rd_b_data_o
);

  logic [COST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_a_data_o <= mem[rd_a_addr_i];
    rd_b_data_o <= mem[rd_b_addr_i];
  end

endmodule

@@ src/msto_engine.sv @@
`include "min_steps_to_one_dp_unit_defines.svh"

module msto_engine import msto_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned AW          = 12
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  msto_req_if.sink          req_i,
  output logic              wr_en_o,
  output logic [AW-1:0]     wr_addr_o,
  output logic [COST_W-1:0] wr_data_o,
  output logic [AW-1:0]     rd_a_addr_o,
  output logic [AW-1:0]     rd_b_addr_o,
  input  logic [COST_W-1:0] rd_a_data_i,
  input  logic [COST_W-1:0] rd_b_data_i,
  output res_t              res_o,
  input  logic              res_take_i
);

  localparam int unsigned CW = AW + 1;
  localparam int unsigned XW = CW + 2;

  state_e state_q, state_d;

  // Next entry to compute; filled range is [0, nxt_q-1]. div3/mod3 track nxt_q / 3.
  logic [CW-1:0]     nxt_q, nxt_d;
  logic [AW-1:0]     div3_q, div3_d;
  logic [1:0]        mod3_q, mod3_d;
  logic [COST_W-1:0] last_cost_q, last_cost_d;
  logic [AW-1:0]     target_q, target_d;

  // Write-back stage: read data for s1_idx_q arrives this cycle.
  logic              s1_valid_q, s1_valid_d;
  logic [AW-1:0]     s1_idx_q, s1_idx_d;
  logic              s1_even_q, s1_even_d;
  logic              s1_by3_q, s1_by3_d;
  logic              s1_half_zero_q, s1_half_zero_d;
  logic              s1_third_zero_q, s1_third_zero_d;
  logic              s1_last_q, s1_last_d;

  logic              res_valid_q, res_valid_d;
  logic [COST_W-1:0] res_count_q, res_count_d;

  logic              accept;
  logic              n_oob;
  logic              n_small;
  logic              n_hit;
  logic [AW-1:0]     n_addr;
  logic              issue_en;
  logic [COST_W-1:0] half_val;
  logic [COST_W-1:0] third_val;
  logic [COST_W-1:0] best;
  logic [COST_W-1:0] new_cost;

  assign n_addr   = AW'(req_i.n_value);
  assign n_oob    = 32'(req_i.n_value) >= TABLE_DEPTH;
  assign n_small  = req_i.n_value <= N_W'(1);
  assign n_hit    = 32'(req_i.n_value) < 32'(nxt_q);
  assign accept   = req_i.valid && req_i.ready;
  assign issue_en = (state_q == ST_EXTEND) && (nxt_q <= {1'b0, target_q});

  // Entries 0 and 1 are never written; they read as zero.
  always_comb begin
    half_val  = s1_half_zero_q  ? COST_ZERO : rd_a_data_i;
    third_val = s1_third_zero_q ? COST_ZERO : rd_b_data_i;
    best      = last_cost_q;
    if (s1_even_q && (half_val < best)) begin
      best = half_val;
    end
    if (s1_by3_q && (third_val < best)) begin
      best = third_val;
    end
    new_cost = (best < COST_MAX) ? best + COST_W'(1) : COST_MAX;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && !n_oob && !n_small) begin
          state_d = n_hit ? ST_LOOKUP : ST_EXTEND;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_IDLE;
      end
      ST_EXTEND: begin
        if (s1_valid_q && s1_last_q) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    req_i.ready = 1'b0;
    rd_a_addr_o = nxt_q[CW-1:1];
    case (state_q)
      ST_IDLE: begin
        req_i.ready = !res_valid_q;
        rd_a_addr_o = n_addr;
      end
      ST_LOOKUP, ST_EXTEND: begin
        req_i.ready = 1'b0;
      end
      default: begin
        req_i.ready = 1'b0;
      end
    endcase
    rd_b_addr_o = div3_q;
    wr_en_o     = s1_valid_q;
    wr_addr_o   = s1_idx_q;
    wr_data_o   = new_cost;
    res_o.valid = res_valid_q;
    res_o.count = res_count_q;
  end

  // Datapath next values
  always_comb begin
    nxt_d           = nxt_q;
    div3_d          = div3_q;
    mod3_d          = mod3_q;
    last_cost_d     = last_cost_q;
    target_d        = target_q;
    s1_valid_d      = issue_en;
    s1_idx_d        = nxt_q[AW-1:0];
    s1_even_d       = !nxt_q[0];
    s1_by3_d        = (mod3_q == 2'd0);
    s1_half_zero_d  = (nxt_q[CW-1:2] == '0);
    s1_third_zero_d = (div3_q[AW-1:1] == '0);
    s1_last_d       = (nxt_q[AW-1:0] == target_q);
    res_valid_d     = res_valid_q && !res_take_i;
    res_count_d     = res_count_q;

    if (issue_en) begin
      nxt_d = nxt_q + CW'(1);
      if (mod3_q == 2'd2) begin
        mod3_d = 2'd0;
        div3_d = div3_q + AW'(1);
      end else begin
        mod3_d = mod3_q + 2'd1;
      end
    end

    if (s1_valid_q) begin
      last_cost_d = new_cost;
    end

    if (accept) begin
      target_d = n_addr;
      if (n_oob) begin
        res_valid_d = 1'b1;
        res_count_d = COST_MAX;
      end else if (n_small) begin
        res_valid_d = 1'b1;
        res_count_d = COST_ZERO;
      end
    end

    if (state_q == ST_LOOKUP) begin
      res_valid_d = 1'b1;
      res_count_d = rd_a_data_i;
    end

    if ((state_q == ST_EXTEND) && s1_valid_q && s1_last_q) begin
      res_valid_d = 1'b1;
      res_count_d = new_cost;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nxt_q       <= CW'(2);
      div3_q      <= '0;
      mod3_q      <= 2'd2;
      last_cost_q <= COST_ZERO;
      s1_valid_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      nxt_q       <= nxt_d;
      div3_q      <= div3_d;
      mod3_q      <= mod3_d;
      last_cost_q <= last_cost_d;
      s1_valid_q  <= s1_valid_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    target_q        <= target_d;
    s1_idx_q        <= s1_idx_d;
    s1_even_q       <= s1_even_d;
    s1_by3_q        <= s1_by3_d;
    s1_half_zero_q  <= s1_half_zero_d;
    s1_third_zero_q <= s1_third_zero_d;
    s1_last_q       <= s1_last_d;
    res_count_q     <= res_count_d;
  end

  `MSTO_ASSERT(a_div3_track, XW'(nxt_q) == XW'(div3_q) * XW'(3) + XW'(mod3_q), "div3/mod3 lost track of next index")
  `MSTO_ASSERT(a_wr_in_extend, s1_valid_q |-> (state_q == ST_EXTEND) && (s1_idx_q >= AW'(2)), "table write outside extension")
  `MSTO_ASSERT(a_wr_sequential, s1_valid_q && $past(s1_valid_q) |-> s1_idx_q == $past(s1_idx_q) + AW'(1), "table entries written out of order")
  `MSTO_ASSERT(a_res_hold, res_valid_q && !res_take_i |=> res_valid_q && $stable(res_count_q), "pending result dropped or changed")

endmodule

@@ src/min_steps_to_one_dp_unit.sv @@
// Channel  Modport  Payload               Handshake
// req_i    sink     n_value    [11:0]     valid/ready, taken when both high
// rsp_o    source   step_count [5:0]      valid/ready, taken when both high
//
// n_value of 0 or 1, or not below TABLE_DEPTH: answered without a table read.
// n_value already in the cost table: answered by one read of the table RAM.
// Otherwise the table is extended up to n_value: one new entry per
// cycle, each reading its half and third on the two RAM read ports.
// Reset only clears control; entries 0 and 1 read as zero, no clearing pass.
// A result waiting on rsp_o does not block the next request.
module min_steps_to_one_dp_unit import msto_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 4096
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  msto_req_if.sink   req_i,
  msto_rsp_if.source rsp_o
);

  localparam int unsigned AW = $clog2(TABLE_DEPTH);

  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  logic [COST_W-1:0] wr_data;
  logic [AW-1:0]     rd_a_addr;
  logic [AW-1:0]     rd_b_addr;
  logic [COST_W-1:0] rd_a_data;
  logic [COST_W-1:0] rd_b_data;
  res_t              res;
  logic              res_take;

  logic              out_valid_q, out_valid_d;
  logic [COST_W-1:0] out_count_q, out_count_d;

  msto_cost_ram #(
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i       (clk_i),
    .wr_en_i     (wr_en),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (wr_data),
    .rd_a_addr_i (rd_a_addr),
    .rd_b_addr_i (rd_b_addr),
    .rd_a_data_o (rd_a_data),
    .rd_b_data_o (rd_b_data)
  );

  msto_engine #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .AW          (AW)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_a_addr_o (rd_a_addr),
    .rd_b_addr_o (rd_b_addr),
    .rd_a_data_i (rd_a_data),
    .rd_b_data_i (rd_b_data),
    .res_o       (res),
    .res_take_i  (res_take)
  );

  assign res_take = res.valid && (!out_valid_q || rsp_o.ready);

  always_comb begin
    out_valid_d = out_valid_q && !rsp_o.ready;
    out_count_d = out_count_q;
    if (res_take) begin
      out_valid_d = 1'b1;
      out_count_d = res.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_count_q <= out_count_d;
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.step_count = out_count_q;

endmodule
